/* hw/rtl/ifa_pkg.sv */
// Shared opcodes, constants and the pipeline stage record of the integer and float ALU.
`default_nettype none
package ifa_pkg;

  localparam logic [4:0] OP_LW    = 5'd0;
  localparam logic [4:0] OP_SW    = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_ADDI  = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_SUBI  = 5'd5;
  localparam logic [4:0] OP_XOR   = 5'd6;
  localparam logic [4:0] OP_BEQZ  = 5'd7;
  localparam logic [4:0] OP_BNEZ  = 5'd8;
  localparam logic [4:0] OP_BLTZ  = 5'd9;
  localparam logic [4:0] OP_BGTZ  = 5'd10;
  localparam logic [4:0] OP_BLEZ  = 5'd11;
  localparam logic [4:0] OP_BGEZ  = 5'd12;
  localparam logic [4:0] OP_JUMP  = 5'd13;
  localparam logic [4:0] OP_LWS   = 5'd16;
  localparam logic [4:0] OP_SWS   = 5'd17;
  localparam logic [4:0] OP_ADDS  = 5'd18;
  localparam logic [4:0] OP_SUBS  = 5'd19;
  localparam logic [4:0] OP_MULTS = 5'd20;
  localparam logic [4:0] OP_DIVS  = 5'd21;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Quotient bits produced by the divider, one per stage.
  localparam int unsigned DivSteps  = 26;
  localparam int unsigned StDiv0    = 4;
  localparam int unsigned StLzc     = StDiv0 + DivSteps;
  localparam int unsigned StShift   = StLzc + 1;
  localparam int unsigned StDenorm  = StLzc + 2;
  localparam int unsigned StRound   = StLzc + 3;
  localparam int unsigned NumStages = StLzc + 4;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_ADD,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic         done;     // result already final (integer, bad opcode or special value)
    logic         bad;
    logic [31:0]  res;
    logic         sign;
    logic         eff_sub;
    logic         sa;
    logic         sb;
    logic [10:0]  ea;
    logic [10:0]  eb;
    logic [23:0]  ma;
    logic [23:0]  mb;
    logic [4:0]   lza;
    logic [4:0]   lzb;
    logic [10:0]  exp;
    logic [27:0]  wm;
    logic [4:0]   lz;
    logic [47:0]  prod;
    logic [24:0]  rem;
    logic [25:0]  quo;
    logic         ovf;
    logic [7:0]   efld;
  } pipe_t;

endpackage
`default_nettype wire

/* hw/rtl/ifa_div_step.sv */
// One restoring division step that yields a single quotient bit.
`default_nettype none
module ifa_div_step
  import ifa_pkg::*;
(
  input  pipe_t stage_i,
  output pipe_t stage_o
);

  logic        ge;
  logic [24:0] diff;

  assign ge   = stage_i.rem >= {1'b0, stage_i.mb};
  assign diff = ge ? stage_i.rem - {1'b0, stage_i.mb} : stage_i.rem;

  always_comb begin
    stage_o = stage_i;
    if (!stage_i.done && stage_i.kind == KIND_DIV) begin
      stage_o.quo = {stage_i.quo[24:0], ge};
      stage_o.rem = {diff[23:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/int_fp_alu.sv */
// Top level of the pipelined integer and single-precision float ALU.
`default_nettype none
// Execute-stage ALU: integer add, subtract and xor, address and branch target sums, and
// binary32 add, subtract, multiply and divide with round to nearest even and denormals kept.
// A new item may enter in every cycle while stall_o is low; the depth comes from the
// divider, which resolves one quotient bit per stage over 26 stages, ahead of a four-stage
// normalize and round tail that all operations share. A stall on the result side holds the
// run of full stages before the output, and holds back the input only once all are full.
// NaN results come out as 32'h7FC00000; unknown opcodes give all ones with bad_opcode_o set.
module int_fp_alu
  import ifa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output      logic        stall_o,
  input  wire logic [4:0]  req_type_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  input  wire logic [31:0] immediate_i,
  input  wire logic [31:0] next_pc_i,
  output      logic        valid_o,
  input  wire logic        stall_i,
  output      logic [31:0] result_o,
  output      logic        bad_opcode_o
);

  function automatic logic [4:0] lzc24(logic [23:0] m);
    logic [4:0] n;
    logic       hit;
    n   = 5'd24;
    hit = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!hit && m[i]) begin
        n   = 5'(23 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(logic [27:0] m);
    logic [4:0] n;
    logic       hit;
    n   = 5'd28;
    hit = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!hit && m[i]) begin
        n   = 5'(27 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic pipe_t f_unpack(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                     logic [31:0] imm, logic [31:0] npc);
    pipe_t       p;
    logic [31:0] bx;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sx;
    p      = '0;
    bx     = (op == OP_SUBS) ? {~b[31], b[30:0]} : b;
    nan_a  = (&a[30:23]) && (|a[22:0]);
    nan_b  = (&b[30:23]) && (|b[22:0]);
    inf_a  = (&a[30:23]) && !(|a[22:0]);
    inf_b  = (&b[30:23]) && !(|b[22:0]);
    zero_a = a[30:0] == 31'd0;
    zero_b = b[30:0] == 31'd0;
    sx     = a[31] ^ b[31];
    p.kind = KIND_INT;
    p.done = 1'b1;
    unique case (op) inside
      OP_ADD:  p.res = a + b;
      OP_ADDI: p.res = a + imm;
      OP_SUB:  p.res = a - b;
      OP_SUBI: p.res = a - imm;
      OP_XOR:  p.res = a ^ b;
      OP_LW, OP_SW, OP_LWS, OP_SWS: p.res = a + imm;
      OP_BEQZ, OP_BNEZ, OP_BLTZ, OP_BGTZ, OP_BLEZ, OP_BGEZ, OP_JUMP: p.res = npc + imm;
      OP_ADDS, OP_SUBS: begin
        p.kind = KIND_ADD;
        p.done = 1'b1;
        if (nan_a || nan_b) p.res = QNAN;
        else if (inf_a && inf_b) p.res = (a[31] != bx[31]) ? QNAN : a;
        else if (inf_a) p.res = a;
        else if (inf_b) p.res = bx;
        else if (zero_a && zero_b) p.res = {a[31] & bx[31], 31'd0};
        else if (zero_a) p.res = bx;
        else if (zero_b) p.res = a;
        else p.done = 1'b0;
      end
      OP_MULTS: begin
        p.kind = KIND_MUL;
        p.done = 1'b1;
        if (nan_a || nan_b) p.res = QNAN;
        else if ((inf_a && zero_b) || (zero_a && inf_b)) p.res = QNAN;
        else if (inf_a || inf_b) p.res = {sx, 8'hFF, 23'd0};
        else if (zero_a || zero_b) p.res = {sx, 31'd0};
        else p.done = 1'b0;
      end
      OP_DIVS: begin
        p.kind = KIND_DIV;
        p.done = 1'b1;
        if (nan_a || nan_b) p.res = QNAN;
        else if (zero_b) p.res = zero_a ? QNAN : {sx, 8'hFF, 23'd0};
        else if (inf_a && inf_b) p.res = QNAN;
        else if (inf_a) p.res = {sx, 8'hFF, 23'd0};
        else if (inf_b || zero_a) p.res = {sx, 31'd0};
        else p.done = 1'b0;
      end
      default: begin
        p.res = ALL_ONES;
        p.bad = 1'b1;
      end
    endcase
    p.sign = sx;
    p.sa   = a[31];
    p.sb   = bx[31];
    p.ea   = (a[30:23] == 8'd0) ? 11'd1 : {3'd0, a[30:23]};
    p.eb   = (b[30:23] == 8'd0) ? 11'd1 : {3'd0, b[30:23]};
    p.ma   = {|a[30:23], a[22:0]};
    p.mb   = {|b[30:23], b[22:0]};
    p.lza  = lzc24(p.ma);
    p.lzb  = lzc24(p.mb);
    return p;
  endfunction

  // Denormal operands are brought to a leading one with a lowered exponent.
  function automatic pipe_t f_norm(pipe_t i);
    pipe_t p;
    p = i;
    if (!i.done) begin
      p.ma = i.ma << i.lza;
      p.mb = i.mb << i.lzb;
      p.ea = i.ea - {6'd0, i.lza};
      p.eb = i.eb - {6'd0, i.lzb};
    end
    return p;
  endfunction

  function automatic pipe_t f_prep(pipe_t i);
    pipe_t p;
    logic  a_big;
    p     = i;
    a_big = ($signed(i.ea) > $signed(i.eb)) || ((i.ea == i.eb) && (i.ma >= i.mb));
    if (!i.done) begin
      case (i.kind)
        KIND_ADD: begin
          p.eff_sub = i.sa ^ i.sb;
          if (!a_big) begin
            p.ea = i.eb;
            p.eb = i.ea;
            p.ma = i.mb;
            p.mb = i.ma;
            p.sa = i.sb;
            p.sb = i.sa;
          end
          p.sign = a_big ? i.sa : i.sb;
        end
        KIND_MUL: begin
          p.prod = i.ma * i.mb;
          p.exp  = i.ea + i.eb - 11'd127;
        end
        KIND_DIV: begin
          p.quo = '0;
          if (i.ma < i.mb) begin
            p.rem = {i.ma, 1'b0};
            p.exp = i.ea - i.eb + 11'd126;
          end else begin
            p.rem = {1'b0, i.ma};
            p.exp = i.ea - i.eb + 11'd127;
          end
        end
        default: p = i;
      endcase
    end
    return p;
  endfunction

  function automatic pipe_t f_align(pipe_t i);
    pipe_t       p;
    logic [10:0] d;
    logic [26:0] full, small_al, big_al;
    logic [27:0] sum;
    logic        sticky;
    p        = i;
    d        = i.ea - i.eb;
    full     = {i.mb, 3'd0};
    big_al   = {i.ma, 3'd0};
    sticky   = |(full & ((27'd1 << d[4:0]) - 27'd1));
    small_al = (d >= 11'd27) ? 27'd1 : ((full >> d[4:0]) | {26'd0, sticky});
    sum      = i.eff_sub ? ({1'b0, big_al} - {1'b0, small_al})
                         : ({1'b0, big_al} + {1'b0, small_al});
    if (!i.done) begin
      case (i.kind)
        KIND_ADD: begin
          p.wm  = sum;
          p.exp = i.ea;
          if (sum == 28'd0) begin
            p.done = 1'b1;
            p.res  = 32'd0;
          end
        end
        KIND_MUL: p.wm = {i.prod[47:21], |i.prod[20:0]};
        default:  p = i;
      endcase
    end
    return p;
  endfunction

  function automatic pipe_t f_lzc(pipe_t i);
    pipe_t p;
    p = i;
    if (!i.done) begin
      if (i.kind == KIND_DIV) begin
        // The quotient always lies in [1, 2), so its leading one sits one below the top.
        p.wm = {1'b0, i.quo, |i.rem};
        p.lz = 5'd1;
      end else begin
        p.lz = lzc28(i.wm);
      end
    end
    return p;
  endfunction

  function automatic pipe_t f_shift(pipe_t i);
    pipe_t p;
    p = i;
    if (!i.done) begin
      p.wm  = i.wm << i.lz;
      p.exp = i.exp + 11'd1 - {6'd0, i.lz};
    end
    return p;
  endfunction

  function automatic pipe_t f_denorm(pipe_t i);
    pipe_t       p;
    logic [10:0] sh;
    logic        sticky;
    p      = i;
    sh     = 11'd1 - i.exp;
    sticky = |(i.wm & ((28'd1 << sh[4:0]) - 28'd1));
    p.ovf  = 1'b0;
    p.efld = 8'd0;
    if ($signed(i.exp) >= $signed(11'd255)) begin
      p.ovf = 1'b1;
    end else if ($signed(i.exp) >= $signed(11'd1)) begin
      p.efld = i.exp[7:0] - 8'd1;
    end else if (sh >= 11'd28) begin
      p.wm = {27'd0, |i.wm};
    end else begin
      p.wm = (i.wm >> sh[4:0]) | {27'd0, sticky};
    end
    return p;
  endfunction

  // The hidden bit adds into the exponent field, so a carry out of rounding lands right.
  function automatic pipe_t f_round(pipe_t i);
    pipe_t       p;
    logic [23:0] mant;
    logic        inc;
    logic [30:0] pk;
    p    = i;
    mant = i.wm[27:4];
    inc  = i.wm[3] & ((|i.wm[2:0]) | mant[0]);
    pk   = {i.efld, 23'd0} + {7'd0, mant} + {30'd0, inc};
    if (!i.done) begin
      p.res = i.ovf ? {i.sign, 8'hFF, 23'd0} : {i.sign, pk};
    end
    return p;
  endfunction

  pipe_t st_d [NumStages];
  pipe_t st_q [NumStages];
  logic  v_q  [NumStages];
  logic  v_in [NumStages];
  logic  en   [NumStages + 1];

  assign en[NumStages] = !stall_i;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    assign en[k] = !v_q[k] || en[k + 1];

    if (k == 0) begin : g_first
      assign v_in[k] = valid_i;
      assign st_d[k] = f_unpack(req_type_i, operand_a_i, operand_b_i, immediate_i, next_pc_i);
    end else begin : g_rest
      assign v_in[k] = v_q[k - 1];
      if (k == 1) begin : g_norm
        assign st_d[k] = f_norm(st_q[k - 1]);
      end else if (k == 2) begin : g_prep
        assign st_d[k] = f_prep(st_q[k - 1]);
      end else if (k == 3) begin : g_align
        assign st_d[k] = f_align(st_q[k - 1]);
      end else if (k < StLzc) begin : g_div
        ifa_div_step u_div_step (
          .stage_i(st_q[k - 1]),
          .stage_o(st_d[k])
        );
      end else if (k == StLzc) begin : g_lzc
        assign st_d[k] = f_lzc(st_q[k - 1]);
      end else if (k == StShift) begin : g_shift
        assign st_d[k] = f_shift(st_q[k - 1]);
      end else if (k == StDenorm) begin : g_denorm
        assign st_d[k] = f_denorm(st_q[k - 1]);
      end else begin : g_round
        assign st_d[k] = f_round(st_q[k - 1]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign stall_o      = !en[0];
  assign valid_o      = v_q[NumStages - 1];
  assign result_o     = st_q[NumStages - 1].res;
  assign bad_opcode_o = st_q[NumStages - 1].bad;

  a_bad_all_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && bad_opcode_o |-> result_o == ALL_ONES)
    else $error("bad opcode item without all-ones result");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled while the result side is free");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !v_q[NumStages - 2] |=> !valid_o)
    else $error("result repeated after it was taken");

endmodule
`default_nettype wire
